/* rtl/core/swg_pkg.sv */
// Shared types and constants for the sliding-window Gini block.
`timescale 1ns / 1ps
package swg_pkg;
	localparam int MAX_WINDOW_DEF  = 512;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int CFG_W           = 16;
	localparam int WDAYS_W         = 10;
	localparam int GINI_W          = 16;
	localparam int VCOUNT_W        = 10;
	localparam int APB_AW          = 4;
	localparam int APB_DW          = 32;
	localparam int DIV_STEPS       = 16;

	localparam logic [WDAYS_W-1:0]      WDAYS_RST     = 10'd365;
	localparam logic signed [CFG_W-1:0] THRESHOLD_RST = -16'sd100;
	localparam logic signed [CFG_W-1:0] NODATA_RST    = 16'sh8000;
	localparam logic [GINI_W-1:0]       GINI_ONE      = 16'h8000;

	typedef enum logic [1:0] {
		REG_WDAYS  = 2'd0,
		REG_THRESH = 2'd1,
		REG_NODATA = 2'd2,
		REG_NONE   = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_HIST, S_OLD, S_REM, S_INS_INIT, S_INS, S_TAIL,
		S_CHK, S_MUL, S_DIV_INIT, S_DIV, S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic hist;
		logic rem_init;
		logic rem_step;
		logic ins_init;
		logic ins_step;
		logic ins_tail;
		logic mul_init;
		logic mul_step;
		logic div_init;
		logic div_step;
		logic publish;
	} cmd_t;

	typedef struct packed {
		logic removing;
		logic rem_last;
		logic ins_last;
		logic report;
		logic sum_pos;
		logic mul_last;
		logic need_div;
		logic div_last;
		logic out_free;
	} sts_t;
endpackage

/* rtl/core/swg_regs.sv */
// Configuration register file on the APB-style port.
`timescale 1ns / 1ps
module swg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [swg_pkg::APB_AW-1:0]          paddr,
	input  logic [swg_pkg::APB_DW-1:0]          pwdata,
	output logic [swg_pkg::APB_DW-1:0]          prdata,
	output logic                                pready,
	output logic [swg_pkg::WDAYS_W-1:0]         window_days,
	output logic signed [swg_pkg::CFG_W-1:0]    threshold,
	output logic signed [swg_pkg::CFG_W-1:0]    nodata_code,
	output logic                                clr
);
	import swg_pkg::*;

	reg_idx_t idx;
	logic     wr;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel & penable & pwrite & pready;
	assign clr    = wr & (idx != REG_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_days <= WDAYS_RST;
			threshold   <= THRESHOLD_RST;
			nodata_code <= NODATA_RST;
		end else if (wr) begin
			unique case (idx)
				REG_WDAYS:  window_days <= pwdata[WDAYS_W-1:0];
				REG_THRESH: threshold   <= pwdata[CFG_W-1:0];
				REG_NODATA: nodata_code <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WDAYS:  prdata = APB_DW'(window_days);
			REG_THRESH: prdata = APB_DW'($unsigned(threshold));
			REG_NODATA: prdata = APB_DW'($unsigned(nodata_code));
			default:    prdata = '0;
		endcase
	end
endmodule

/* rtl/core/swg_ctrl.sv */
// Sequencer for one transaction: history, remove, insert with sums, multiply, divide.
`timescale 1ns / 1ps
module swg_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  swg_pkg::sts_t  sts,
	output swg_pkg::cmd_t  cmd
);
	import swg_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_HIST;
				end
			end
			S_HIST: begin
				cmd.hist = 1'b1;
				state_d  = S_OLD;
			end
			S_OLD: begin
				cmd.rem_init = 1'b1;
				state_d      = sts.removing ? S_REM : S_INS_INIT;
			end
			S_REM: begin
				cmd.rem_step = 1'b1;
				if (sts.rem_last) state_d = S_INS_INIT;
			end
			S_INS_INIT: begin
				cmd.ins_init = 1'b1;
				state_d      = S_INS;
			end
			S_INS: begin
				cmd.ins_step = 1'b1;
				if (sts.ins_last) state_d = S_TAIL;
			end
			S_TAIL: begin
				cmd.ins_tail = 1'b1;
				state_d      = S_CHK;
			end
			S_CHK: begin
				if (!sts.report) begin
					state_d = S_IDLE;
				end else if (!sts.sum_pos) begin
					state_d = S_DONE;
				end else begin
					cmd.mul_init = 1'b1;
					state_d      = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (sts.mul_last) state_d = S_DIV_INIT;
			end
			S_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (!sts.need_div || sts.div_last) state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

/* rtl/core/swg_dp.sv */
// Datapath: history ring, sorted store, running sums, shift-add multiplier, divider, output register.
`timescale 1ns / 1ps
module swg_dp #(
	parameter int MAX_WINDOW  = swg_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = swg_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [swg_pkg::WDAYS_W-1:0]         window_days,
	input  logic signed [swg_pkg::CFG_W-1:0]    threshold,
	input  logic signed [swg_pkg::CFG_W-1:0]    nodata_code,
	input  logic                                clr,
	input  swg_pkg::cmd_t                       cmd,
	output swg_pkg::sts_t                       sts,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	output logic [swg_pkg::GINI_W-1:0]          gini_index,
	output logic                                no_data,
	output logic [swg_pkg::VCOUNT_W-1:0]        valid_count,
	output logic                                out_valid,
	input  logic                                out_ready
);
	import swg_pkg::*;

	localparam int PTR_W  = $clog2(MAX_WINDOW);
	localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W  = SAMPLE_BITS + CNT_W + 1;
	localparam int TSUM_W = SAMPLE_BITS + 2 * CNT_W + 1;
	localparam int P_W    = TSUM_W + 2;
	localparam int CMP_W  = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
	localparam int WX_W   = (CNT_W > WDAYS_W) ? CNT_W : WDAYS_W;
	localparam int MC_W   = $clog2(CNT_W + 1);
	localparam int DC_W   = $clog2(DIV_STEPS);

	function automatic logic is_valid(input logic signed [SAMPLE_BITS-1:0] v,
			input logic signed [CFG_W-1:0] thr, input logic signed [CFG_W-1:0] nd);
		logic signed [CMP_W-1:0] ve;
		ve = CMP_W'(v);
		return (ve >= CMP_W'(thr)) && (ve != CMP_W'(nd));
	endfunction

	logic [SAMPLE_BITS-1:0]        hist_mem [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0]        store_mem [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] sample_q, hist_rd_q, st_rd_q, carry_q;
	logic [PTR_W-1:0]              rp_q, old_addr;
	logic [CNT_W-1:0]              fill_q, n_q, ridx_q, pidx_q, wlen;
	logic [WX_W-1:0]               wd_ext;
	logic [CNT_W:0]                rp_e;
	logic                          full_q, pv_q, found_q, ins_q, do_ins_q;
	logic signed [SUM_W-1:0]       sum_q, sum_nx;
	logic signed [TSUM_W-1:0]      tsum_q;
	logic signed [P_W-1:0]         num_q, num_nx;
	logic [P_W-1:0]                prod_q, mcand_q, den_q, rem_q, rem_sh;
	logic [CNT_W-1:0]              mplier_q;
	logic [MC_W-1:0]               mcnt_q;
	logic [GINI_W-1:0]             quo_q;
	logic [DC_W-1:0]               dcnt_q;
	logic [GINI_W:0]               rounded;
	logic                          st_we, take, acc;
	logic [PTR_W-1:0]              st_waddr;
	logic signed [SAMPLE_BITS-1:0] st_wdata, elem;

	// effective window length
	always_comb begin
		wd_ext = WX_W'(window_days);
		if (window_days == '0) begin
			wlen = CNT_W'(1);
		end else if (wd_ext > WX_W'(MAX_WINDOW)) begin
			wlen = CNT_W'(MAX_WINDOW);
		end else begin
			wlen = CNT_W'(wd_ext);
		end
		rp_e = (CNT_W + 1)'(rp_q);
		if (rp_e >= (CNT_W + 1)'(wlen)) begin
			old_addr = PTR_W'(rp_e - (CNT_W + 1)'(wlen));
		end else begin
			old_addr = PTR_W'(rp_e + (CNT_W + 1)'(MAX_WINDOW) - (CNT_W + 1)'(wlen));
		end
	end

	// history ring
	always_ff @(posedge clk) begin
		if (cmd.hist) begin
			hist_mem[rp_q] <= sample_q;
			hist_rd_q      <= hist_mem[old_addr];
		end
	end

	// sorted store write selection
	always_comb begin
		st_we    = 1'b0;
		st_waddr = pidx_q[PTR_W-1:0];
		st_wdata = st_rd_q;
		elem     = st_rd_q;
		take     = 1'b0;
		acc      = 1'b0;
		if (cmd.rem_step && pv_q && found_q) begin
			st_we    = 1'b1;
			st_waddr = PTR_W'(pidx_q - CNT_W'(1));
		end
		if (cmd.ins_step && pv_q) begin
			acc = 1'b1;
			if (ins_q) begin
				st_we    = 1'b1;
				st_wdata = carry_q;
				elem     = carry_q;
			end else if (do_ins_q && (sample_q < st_rd_q)) begin
				st_we    = 1'b1;
				st_wdata = sample_q;
				elem     = sample_q;
				take     = 1'b1;
			end
		end
		if (cmd.ins_tail && do_ins_q) begin
			acc      = 1'b1;
			st_we    = 1'b1;
			st_waddr = n_q[PTR_W-1:0];
			st_wdata = ins_q ? carry_q : sample_q;
			elem     = st_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) store_mem[st_waddr] <= st_wdata;
		st_rd_q <= store_mem[ridx_q[PTR_W-1:0]];
	end

	assign sum_nx = sum_q + SUM_W'(elem);
	assign num_nx = $signed(prod_q) + P_W'(sum_q) - (P_W'(tsum_q) <<< 1);
	assign rem_sh = rem_q << 1;

	// window control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q   <= '0;
			fill_q <= '0;
			n_q    <= '0;
			full_q <= 1'b0;
		end else if (clr) begin
			rp_q   <= '0;
			fill_q <= '0;
			n_q    <= '0;
		end else begin
			if (cmd.hist) begin
				full_q <= (fill_q >= wlen);
				if (fill_q < wlen) fill_q <= fill_q + CNT_W'(1);
				rp_q <= (rp_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : rp_q + PTR_W'(1);
			end
			if (cmd.rem_step && pv_q && (pidx_q == n_q - CNT_W'(1))) n_q <= n_q - CNT_W'(1);
			if (cmd.ins_tail && do_ins_q) n_q <= n_q + CNT_W'(1);
		end
	end

	// scan, sums, multiply, divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ridx_q  <= '0;
			pidx_q  <= '0;
			pv_q    <= 1'b0;
			found_q <= 1'b0;
			ins_q   <= 1'b0;
			do_ins_q <= 1'b0;
			mcnt_q  <= '0;
			dcnt_q  <= '0;
		end else begin
			if (cmd.rem_init || cmd.ins_init) begin
				ridx_q <= '0;
				pv_q   <= 1'b0;
			end else if (cmd.rem_step || cmd.ins_step) begin
				pidx_q <= ridx_q;
				if (ridx_q < n_q) begin
					ridx_q <= ridx_q + CNT_W'(1);
					pv_q   <= 1'b1;
				end else begin
					pv_q <= 1'b0;
				end
			end
			if (cmd.rem_init) found_q <= 1'b0;
			if (cmd.rem_step && pv_q && !found_q && (st_rd_q == hist_rd_q)) found_q <= 1'b1;
			if (cmd.ins_init) begin
				ins_q    <= 1'b0;
				do_ins_q <= is_valid(sample_q, threshold, nodata_code)
					&& (n_q < CNT_W'(MAX_WINDOW));
			end
			if (take) ins_q <= 1'b1;
			if (cmd.mul_init) mcnt_q <= '0;
			if (cmd.mul_step) mcnt_q <= mcnt_q + MC_W'(1);
			if (cmd.div_init) dcnt_q <= '0;
			if (cmd.div_step) dcnt_q <= dcnt_q + DC_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) sample_q <= sample;
		if (cmd.ins_step && pv_q && (ins_q || take)) carry_q <= st_rd_q;
		if (cmd.ins_init) begin
			sum_q  <= '0;
			tsum_q <= '0;
		end else if (acc) begin
			sum_q  <= sum_nx;
			tsum_q <= tsum_q + TSUM_W'(sum_nx);
		end
		if (cmd.mul_init) begin
			prod_q   <= '0;
			mcand_q  <= P_W'(sum_q);
			mplier_q <= n_q;
		end else if (cmd.mul_step) begin
			if (mplier_q[0]) prod_q <= prod_q + mcand_q;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
		if (cmd.div_init) begin
			num_q <= num_nx;
			den_q <= prod_q;
			rem_q <= $unsigned(num_nx);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_sh >= den_q) begin
				rem_q <= rem_sh - den_q;
				quo_q <= {quo_q[GINI_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[GINI_W-2:0], 1'b0};
			end
		end
	end

	// output register
	assign rounded = ((GINI_W + 1)'(quo_q) + (GINI_W + 1)'(1)) >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.publish) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			no_data     <= (sum_q <= 0);
			valid_count <= VCOUNT_W'(n_q);
			if (sum_q <= 0 || num_q <= 0) begin
				gini_index <= '0;
			end else if ($unsigned(num_q) >= den_q) begin
				gini_index <= GINI_ONE;
			end else begin
				gini_index <= rounded[GINI_W-1:0];
			end
		end
	end

	always_comb begin
		sts          = '0;
		sts.removing = full_q && is_valid(hist_rd_q, threshold, nodata_code) && (n_q != '0);
		sts.rem_last = pv_q && (pidx_q == n_q - CNT_W'(1));
		sts.ins_last = (n_q == '0) || (pv_q && (pidx_q == n_q - CNT_W'(1)));
		sts.report   = (fill_q >= wlen);
		sts.sum_pos  = (sum_q > 0);
		sts.mul_last = (mcnt_q == MC_W'(CNT_W - 1));
		sts.need_div = (num_q > 0) && ($unsigned(num_q) < den_q);
		sts.div_last = (dcnt_q == DC_W'(DIV_STEPS - 1));
		sts.out_free = !out_valid || out_ready;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CNT_W'(MAX_WINDOW))
		else $error("store count beyond capacity");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hist |=> (fill_q <= wlen))
		else $error("fill count beyond window length");
	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!out_valid || out_ready))
		else $error("result overwrites a pending transaction");
	a_remove_found: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rem_step && sts.rem_last) |-> (found_q || (st_rd_q == hist_rd_q)))
		else $error("leaving sample missing from sorted store");
endmodule

/* rtl/core/sliding_window_gini.sv */
// Top level of the sliding-window Gini block.
// channel  | dir | signals                          | contents
// s_*      | in  | tvalid tready tdata              | sample
// m_*      | out | tvalid tready tdata tuser        | gini_index, valid_count; no_data
// apb      | in  | psel penable pwrite paddr pwdata | window_days, threshold, nodata_code
// A transaction's length grows with n, the valid count: it is set by the single-port walks
// of the sorted store for removal and for insertion.
// The multiply is shift-add and the divide is a restoring divide.
// A result waits in the output register while the next sample is taken.
// Reset or a write to any of the three configuration registers empties the window; memories need no clearing.
`timescale 1ns / 1ps
module sliding_window_gini #(
	parameter int MAX_WINDOW  = swg_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = swg_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // sample
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	output logic [31:0]                              m_tdata,  // gini_index, valid_count
	output logic                                     m_tuser,  // no_data
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic [swg_pkg::APB_AW-1:0]               paddr,
	input  logic [swg_pkg::APB_DW-1:0]               pwdata,
	output logic [swg_pkg::APB_DW-1:0]               prdata,
	output logic                                     pready
);
	import swg_pkg::*;

	logic [WDAYS_W-1:0]      window_days;
	logic signed [CFG_W-1:0] threshold, nodata_code;
	logic                    clr;
	cmd_t                    cmd;
	sts_t                    sts;
	logic [GINI_W-1:0]       gini_index;
	logic [VCOUNT_W-1:0]     valid_count;

	assign m_tdata = {(32 - GINI_W - VCOUNT_W)'(0), valid_count, gini_index};

	swg_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.window_days, .threshold, .nodata_code, .clr
	);

	swg_ctrl u_ctrl (
		.clk, .arst_n, .s_tvalid, .s_tready, .sts, .cmd
	);

	swg_dp #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
		.clk, .arst_n, .window_days, .threshold, .nodata_code, .clr, .cmd, .sts,
		.sample      (s_tdata[SAMPLE_BITS-1:0]),
		.gini_index,
		.no_data     (m_tuser),
		.valid_count,
		.out_valid   (m_tvalid),
		.out_ready   (m_tready)
	);
endmodule

/* tb/sv/tb_sliding_window_gini.sv */
// Testbench for the sliding-window Gini block: stream stimulus, APB set-up, result checks.
`timescale 1ns / 1ps
module tb_sliding_window_gini;
	import swg_pkg::*;

	localparam int WIN_MAX     = 512;
	localparam int SETTLE      = 1200;
	localparam int CYCLE_LIMIT = 5000000;

	typedef struct {
		logic [15:0] gini;
		logic        nodata;
		logic [9:0]  vcount;
	} gini_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // sample
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // gini_index [15:0], valid_count [25:16]
	logic        m_tuser;   // no_data
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic        pready;

	sliding_window_gini u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic signed [15:0] hist_ring [WIN_MAX];
	int                 sorted_vals [$];
	int unsigned        ring_ptr;
	int unsigned        fill_cnt;
	logic [9:0]         win_days;
	logic signed [15:0] thresh;
	logic signed [15:0] nodata_val;

	gini_result_t pending_gini [$];
	int           mismatches;
	int unsigned  hold_left;
	int unsigned  cycles;
	bit           burst_mode;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_val, $realtime);
		mismatches++;
	endtask

	function automatic bit sample_ok(input logic signed [15:0] v);
		return v >= thresh && v != nodata_val;
	endfunction

	function automatic int unsigned eff_window();
		if (win_days == 0)
			return 1;
		if (win_days > WIN_MAX)
			return WIN_MAX;
		return win_days;
	endfunction

	function automatic void drop_nearest(input int v);
		int at;
		longint best;
		longint d;
		if (sorted_vals.size() == 0)
			return;
		at = 0;
		best = v - sorted_vals[0];
		if (best < 0)
			best = -best;
		for (int i = 1; i < sorted_vals.size(); i++) begin
			d = v - sorted_vals[i];
			if (d < 0)
				d = -d;
			if (d < best) begin
				best = d;
				at = i;
			end
		end
		sorted_vals.delete(at);
	endfunction

	function automatic void add_sorted(input int v);
		int at;
		if (sorted_vals.size() >= WIN_MAX)
			return;
		at = sorted_vals.size();
		for (int i = 0; i < sorted_vals.size(); i++) begin
			if (v < sorted_vals[i]) begin
				at = i;
				break;
			end
		end
		sorted_vals.insert(at, v);
	endfunction

	function automatic void predict_gini(input logic signed [15:0] s);
		int unsigned w;
		int unsigned n;
		longint sum;
		longint tsum;
		longint num;
		longint den;
		longint q;
		longint r;
		gini_result_t res;
		w = eff_window();
		if (ring_ptr >= WIN_MAX)
			ring_ptr = 0;
		if (fill_cnt >= w) begin
			if (sample_ok(hist_ring[(ring_ptr + WIN_MAX - w) % WIN_MAX]))
				drop_nearest(hist_ring[(ring_ptr + WIN_MAX - w) % WIN_MAX]);
		end else
			fill_cnt++;
		hist_ring[ring_ptr] = s;
		ring_ptr = (ring_ptr + 1) % WIN_MAX;
		if (sample_ok(s))
			add_sorted(s);
		if (fill_cnt < w)
			return;
		n = sorted_vals.size();
		sum = 0;
		tsum = 0;
		foreach (sorted_vals[i]) begin
			sum += sorted_vals[i];
			tsum += sum;
		end
		res.vcount = n[9:0];
		res.nodata = 1'b0;
		res.gini = '0;
		if (sum <= 0)
			res.nodata = 1'b1;
		else begin
			num = longint'(n + 1) * sum - 2 * tsum;
			den = longint'(n) * sum;
			if (num >= den)
				res.gini = GINI_ONE;
			else if (num > 0) begin
				q = 0;
				r = num;
				for (int k = 0; k < DIV_STEPS; k++) begin
					r = r << 1;
					q = q << 1;
					if (r >= den) begin
						r -= den;
						q |= 1;
					end
				end
				res.gini = 16'((q + 1) >> 1);
			end
		end
		pending_gini.push_back(res);
	endfunction

	// result checker
	always @(posedge clk) begin
		gini_result_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_gini.size() == 0)
				report_mismatch("unexpected transaction, gini", m_tdata[15:0], -1);
			else begin
				exp_res = pending_gini.pop_front();
				if (m_tdata[15:0] !== exp_res.gini)
					report_mismatch("gini_index", m_tdata[15:0], exp_res.gini);
				if (m_tuser !== exp_res.nodata)
					report_mismatch("no_data", m_tuser, exp_res.nodata);
				if (m_tdata[25:16] !== exp_res.vcount)
					report_mismatch("valid_count", m_tdata[25:16], exp_res.vcount);
			end
		end
	end

	// receiver: random stalls, plus a long hold on request
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (!burst_mode && $urandom_range(0, 7) == 0)
					stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
						: $urandom_range(1, 4);
			end
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic apb_write(input reg_idx_t idx, input logic [15:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(4 * int'(idx));
		pwdata <= {16'h0000, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_WDAYS:  win_days = val[9:0];
			REG_THRESH: thresh = val;
			REG_NODATA: nodata_val = val;
			default: ;
		endcase
		ring_ptr = 0;
		fill_cnt = 0;
		sorted_vals.delete();
	endtask

	task automatic send_sample(input logic [15:0] s);
		int unsigned gap;
		s_tdata <= s;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!(s_tvalid && s_tready));
		predict_gini(s);
		gap = 0;
		if (!burst_mode) begin
			case ($urandom_range(0, 15))
				10, 11, 12, 13, 14: gap = $urandom_range(1, 3);
				15:                 gap = $urandom_range(10, 60);
				default:            gap = 0;
			endcase
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering, let every expected result arrive, then let the block go quiet
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_gini.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return nodata_val;
			1:       return thresh;
			2:       return thresh - 16'sd1;
			3:       return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
			4, 5, 6: return 16'($urandom_range(0, 1000));
			7:       return thresh + 16'($urandom_range(0, 50));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic test_directed();
		logic [15:0] first_vals [$];
		logic [15:0] tie_vals [$];
		first_vals = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFF9C, 16'hFF9B, 16'h0001,
			16'h5555, 16'hAAAA};
		tie_vals = '{16'd5, 16'd5, 16'd3, 16'd4, 16'd4, 16'd6, 16'd2, 16'd4, 16'hFFFF,
			16'd0, 16'd7, 16'd7, 16'd1, 16'd8};
		apb_write(REG_THRESH, 16'hFF9C);
		apb_write(REG_NODATA, 16'h8000);
		apb_write(REG_WDAYS, 16'd0);
		foreach (first_vals[i])
			send_sample(first_vals[i]);
		drain();
		apb_write(REG_WDAYS, 16'd3);
		foreach (tie_vals[i])
			send_sample(tie_vals[i]);
		drain();
	endtask

	task automatic test_widest_window();
		apb_write(REG_THRESH, 16'h8000);
		apb_write(REG_NODATA, 16'h7FFF);
		apb_write(REG_WDAYS, 16'h03FF);
		for (int i = 0; i < 530; i++)
			send_sample(($urandom_range(0, 15) == 0) ? pick_sample()
				: 16'($urandom_range(0, 2000)));
		drain();
	endtask

	task automatic test_random_settings();
		int unsigned count;
		for (int ph = 0; ph < 10; ph++) begin
			case ($urandom_range(0, 3))
				0:       apb_write(REG_THRESH, 16'h8000);
				1:       apb_write(REG_THRESH, 16'h7FFF);
				default: apb_write(REG_THRESH, 16'($signed($urandom_range(0, 200)) - 100));
			endcase
			apb_write(REG_NODATA, ($urandom_range(0, 1) != 0) ? 16'h8000
				: 16'($urandom_range(0, 65535)));
			apb_write(REG_WDAYS, 16'($urandom_range(1, 24)));
			burst_mode = (ph % 4 == 3);
			count = $urandom_range(30, 60);
			for (int i = 0; i < count; i++)
				send_sample(pick_sample());
			drain();
		end
		burst_mode = 1'b0;
	endtask

	task automatic test_output_hold();
		apb_write(REG_THRESH, 16'h0000);
		apb_write(REG_WDAYS, 16'd2);
		hold_left = 3000;
		for (int i = 0; i < 20; i++)
			send_sample(pick_sample());
		drain();
	endtask

	task automatic test_sender_pause();
		apb_write(REG_WDAYS, 16'd5);
		for (int i = 0; i < 30; i++)
			send_sample(pick_sample());
		s_tvalid <= 1'b0;
		while (pending_gini.size() != 0)
			@(posedge clk);
		for (int i = 0; i < 30; i++)
			send_sample(pick_sample());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatches = 0;
		hold_left = 0;
		burst_mode = 1'b0;
		ring_ptr = 0;
		fill_cnt = 0;
		win_days = WDAYS_RST;
		thresh = THRESHOLD_RST;
		nodata_val = NODATA_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_widest_window();
		test_random_settings();
		test_output_hold();
		test_sender_pause();
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

/* sim.f */
rtl/core/swg_pkg.sv
rtl/core/swg_regs.sv
rtl/core/swg_ctrl.sv
rtl/core/swg_dp.sv
rtl/core/sliding_window_gini.sv
tb/sv/tb_sliding_window_gini.sv
